// ----- rtl/wls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wls_pkg
// Shared types and constants of the windowed latency statistics unit.
// ----------------------------------------------------------------------------
package wls_pkg;

  localparam int WINDOW      = 240;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_BITS    = $clog2(WINDOW);
  localparam int CNT_BITS    = $clog2(WINDOW + 1);
  localparam int TOTAL_BITS  = SAMPLE_BITS + CNT_BITS;
  localparam int EDGE_BITS   = 16;
  localparam int BAND_BITS   = 3;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam logic [EDGE_BITS-1:0] EDGE_ONE_RST   = 16'd30;
  localparam logic [EDGE_BITS-1:0] EDGE_TWO_RST   = 16'd55;
  localparam logic [EDGE_BITS-1:0] EDGE_THREE_RST = 16'd80;
  localparam logic [EDGE_BITS-1:0] EDGE_FOUR_RST  = 16'd100;

  typedef enum logic [1:0] {
    REG_EDGE_ONE   = 2'd0,
    REG_EDGE_TWO   = 2'd1,
    REG_EDGE_THREE = 2'd2,
    REG_EDGE_FOUR  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_UPDATE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [EDGE_BITS-1:0] one;
    logic [EDGE_BITS-1:0] two;
    logic [EDGE_BITS-1:0] three;
    logic [EDGE_BITS-1:0] four;
  } edges_t;

  typedef struct packed {
    logic take_sample;
    logic rd_old;
    logic update;
    logic scan_step;
    logic div_start;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/wls_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wls_div
// Restoring divider, one quotient bit per cycle, for the window mean.
// ----------------------------------------------------------------------------
module wls_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wls_pkg::TOTAL_BITS-1:0] dividend_i,
  input  logic [wls_pkg::CNT_BITS-1:0]   divisor_i,
  output logic                           busy_o,
  output logic [wls_pkg::TOTAL_BITS-1:0] quotient_o
);
  import wls_pkg::*;

  localparam int STEP_BITS = $clog2(TOTAL_BITS + 1);

  logic [CNT_BITS-1:0]   rem_q, rem_d;
  logic [TOTAL_BITS-1:0] quo_q, quo_d;
  logic [STEP_BITS-1:0]  step_q, step_d;
  logic                  busy_q, busy_d;
  logic [CNT_BITS:0]     trial;

  always_comb begin
    trial  = {rem_q, quo_q[TOTAL_BITS-1]};
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      step_d = STEP_BITS'(TOTAL_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = CNT_BITS'(trial - {1'b0, divisor_i});
        quo_d = {quo_q[TOTAL_BITS-2:0], 1'b1};
      end else begin
        rem_d = trial[CNT_BITS-1:0];
        quo_d = {quo_q[TOTAL_BITS-2:0], 1'b0};
      end
      step_d = step_q - STEP_BITS'(1);
      busy_d = (step_q != STEP_BITS'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/wls_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wls_dp
// Sample ring, running total, min/max scan, mean divider, banding, output word.
// ----------------------------------------------------------------------------
module wls_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wls_pkg::dp_cmd_t              cmd_i,
  output wls_pkg::dp_status_t           status_o,
  input  wls_pkg::edges_t               edges_i,
  input  logic [15:0]                   latency_ms_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [wls_pkg::BAND_BITS-1:0] last_band_o,
  output logic [15:0]                   window_mean_o,
  output logic [wls_pkg::BAND_BITS-1:0] mean_band_o,
  output logic [15:0]                   window_spread_o,
  output logic [wls_pkg::BAND_BITS-1:0] spread_band_o,
  output logic [7:0]                    fill_count_o
);
  import wls_pkg::*;

  function automatic logic [BAND_BITS-1:0] grade(input logic [EDGE_BITS-1:0] v,
                                                 input edges_t e);
    logic [BAND_BITS-1:0] b;
    if (v < e.one)        b = BAND_BITS'(0);
    else if (v < e.two)   b = BAND_BITS'(1);
    else if (v < e.three) b = BAND_BITS'(2);
    else if (v < e.four)  b = BAND_BITS'(3);
    else                  b = BAND_BITS'(4);
    return b;
  endfunction

  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic [IDX_BITS-1:0]    rd_addr;

  logic [SAMPLE_BITS-1:0] sample_q;
  logic [IDX_BITS-1:0]    slot_q, slot_d;
  logic [CNT_BITS-1:0]    count_q, count_d;
  logic [TOTAL_BITS-1:0]  total_q, total_d;
  logic [IDX_BITS-1:0]    scan_idx_q, scan_idx_d;
  logic                   rd_pend_q, first_q, first_d;
  logic [SAMPLE_BITS-1:0] lo_q, lo_d, hi_q, hi_d;
  logic                   full;

  logic                   div_busy;
  logic [TOTAL_BITS-1:0]  quotient;
  logic [SAMPLE_BITS-1:0] mean;
  logic [SAMPLE_BITS-1:0] spread;

  logic                   out_valid_q;
  logic                   out_free;

  assign full    = (count_q == CNT_BITS'(WINDOW));
  assign rd_addr = cmd_i.rd_old ? slot_q : scan_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      ring_mem[slot_q] <= sample_q;
    end
    rd_data_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_sample) begin
      sample_q <= latency_ms_i;
    end
  end

  always_comb begin
    slot_d     = slot_q;
    count_d    = count_q;
    total_d    = total_q;
    scan_idx_d = scan_idx_q;
    first_d    = first_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    if (cmd_i.update) begin
      // drop the overwritten sample, then add the new one
      total_d = total_q - (full ? TOTAL_BITS'(rd_data_q) : '0)
                + TOTAL_BITS'(sample_q);
      slot_d  = (slot_q >= IDX_BITS'(WINDOW - 1)) ? '0 : slot_q + IDX_BITS'(1);
      if (!full) begin
        count_d = count_q + CNT_BITS'(1);
      end
      scan_idx_d = '0;
      first_d    = 1'b1;
    end
    if (cmd_i.scan_step) begin
      scan_idx_d = scan_idx_q + IDX_BITS'(1);
    end
    if (rd_pend_q) begin
      first_d = 1'b0;
      if (first_q) begin
        lo_d = rd_data_q;
        hi_d = rd_data_q;
      end else begin
        if (rd_data_q < lo_q) lo_d = rd_data_q;
        if (rd_data_q > hi_q) hi_d = rd_data_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      count_q    <= '0;
      total_q    <= '0;
      scan_idx_q <= '0;
      rd_pend_q  <= 1'b0;
      first_q    <= 1'b0;
    end else begin
      slot_q     <= slot_d;
      count_q    <= count_d;
      total_q    <= total_d;
      scan_idx_q <= scan_idx_d;
      rd_pend_q  <= cmd_i.scan_step;
      first_q    <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  wls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (total_q),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  assign mean   = quotient[SAMPLE_BITS-1:0];
  assign spread = hi_q - lo_q;

  // output word register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      last_band_o     <= grade(EDGE_BITS'(sample_q), edges_i);
      window_mean_o   <= 16'(mean);
      mean_band_o     <= grade(EDGE_BITS'(mean), edges_i);
      window_spread_o <= 16'(spread);
      spread_band_o   <= grade(EDGE_BITS'(spread), edges_i);
      fill_count_o    <= 8'(count_q);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.scan_last = ((CNT_BITS'(scan_idx_q) + CNT_BITS'(1)) == count_q);
  assign status_o.div_busy  = div_busy;
  assign status_o.out_free  = out_free;

endmodule

// ----- rtl/wls_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wls_ctrl
// Sequencer: take a sample, update the ring, scan it, divide, hand off.
// ----------------------------------------------------------------------------
module wls_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wls_pkg::dp_status_t status_i,
  output wls_pkg::dp_cmd_t    cmd_o
);
  import wls_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.take_sample = in_valid_i;
        if (in_valid_i) state_d = ST_RD_OLD;
      end
      ST_RD_OLD: begin
        // fetch the slot about to be overwritten
        cmd_o.rd_old = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) state_d = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        // last read word lands in min/max here
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (!status_i.div_busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/windowed_latency_stats_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_latency_stats_unit
// Sliding window mean, spread and five-way banding of latency samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one latency_ms_i word per handshake (in_valid_i/in_ready_o).
//   Output channel: one result word per input (out_valid_o/out_ready_i) with
//   the sample band, window mean and band, spread and band, and fill count.
//   APB port: four band edge registers at byte addresses 0, 4, 8 and 12.
//   One sample is processed at a time. After acceptance the slot to be
//   overwritten is read, the ring and total are updated, then the min/max scan
//   reads one ring entry per cycle through the single memory read port over
//   all held entries (up to 240), and the mean comes from a 24-step serial
//   divider. No new sample is accepted while one is in progress.
//   in_ready_o rises again once the result is loaded into the output register,
//   so the next sample can be taken while that result waits for out_ready_i.
//   When the receiver stalls, a finished result waits in its sequencer state
//   until the output register frees up.
//   Reset empties the window (count, write slot and total cleared), restores
//   the default band edges and drops any pending result; the ring memory is
//   not cleared, since only written entries are ever scanned.
// ----------------------------------------------------------------------------
module windowed_latency_stats_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [15:0]                   latency_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    last_band_o,
  output logic [15:0]                   window_mean_o,
  output logic [2:0]                    mean_band_o,
  output logic [15:0]                   window_spread_o,
  output logic [2:0]                    spread_band_o,
  output logic [7:0]                    fill_count_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wls_pkg::ADDR_BITS-1:0] paddr,
  input  logic [wls_pkg::DATA_BITS-1:0] pwdata,
  output logic [wls_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import wls_pkg::*;

  edges_t     edges_q;
  dp_cmd_t    cmd;
  dp_status_t status;
  reg_idx_e   reg_idx;
  logic       reg_we;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign reg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edges_q.one   <= EDGE_ONE_RST;
      edges_q.two   <= EDGE_TWO_RST;
      edges_q.three <= EDGE_THREE_RST;
      edges_q.four  <= EDGE_FOUR_RST;
    end else if (reg_we) begin
      unique case (reg_idx)
        REG_EDGE_ONE:   edges_q.one   <= pwdata[EDGE_BITS-1:0];
        REG_EDGE_TWO:   edges_q.two   <= pwdata[EDGE_BITS-1:0];
        REG_EDGE_THREE: edges_q.three <= pwdata[EDGE_BITS-1:0];
        REG_EDGE_FOUR:  edges_q.four  <= pwdata[EDGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_EDGE_ONE:   prdata = DATA_BITS'(edges_q.one);
      REG_EDGE_TWO:   prdata = DATA_BITS'(edges_q.two);
      REG_EDGE_THREE: prdata = DATA_BITS'(edges_q.three);
      REG_EDGE_FOUR:  prdata = DATA_BITS'(edges_q.four);
      default:        prdata = '0;
    endcase
  end

  wls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wls_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .edges_i         (edges_q),
    .latency_ms_i    (latency_ms_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .last_band_o     (last_band_o),
    .window_mean_o   (window_mean_o),
    .mean_band_o     (mean_band_o),
    .window_spread_o (window_spread_o),
    .spread_band_o   (spread_band_o),
    .fill_count_o    (fill_count_o)
  );

endmodule

// ----- rtl/wls_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wls_checker
// Port-level checks of the windowed latency statistics unit.
// ----------------------------------------------------------------------------
module wls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  last_band_o,
  input logic [15:0] window_mean_o,
  input logic [2:0]  mean_band_o,
  input logic [15:0] window_spread_o,
  input logic [2:0]  spread_band_o,
  input logic [7:0]  fill_count_o
);
  import wls_pkg::*;

  // one sample at a time: ready drops right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready stayed high after an accepted word");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_count_o != 8'd0) && (fill_count_o <= 8'(WINDOW)))
    else $error("fill count out of range");

  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_band_o <= 3'd4) && (mean_band_o <= 3'd4)
                    && (spread_band_o <= 3'd4))
    else $error("band code out of range");

  // a single sample has no spread
  a_single_no_spread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fill_count_o == 8'd1) |-> (window_spread_o == 16'd0))
    else $error("nonzero spread with one held sample");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(window_mean_o)
                                    && $stable(fill_count_o))
    else $error("stalled result word changed");

endmodule

bind windowed_latency_stats_unit wls_checker u_wls_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .last_band_o     (last_band_o),
  .window_mean_o   (window_mean_o),
  .mean_band_o     (mean_band_o),
  .window_spread_o (window_spread_o),
  .spread_band_o   (spread_band_o),
  .fill_count_o    (fill_count_o)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the windowed latency statistics unit.
// ----------------------------------------------------------------------------
// A short table of directed words covers the field extremes, the band
// boundaries, unordered edges and edges at both range ends. Six random
// phases follow. Each phase first rewrites all band edges through APB and
// reads them back. Its samples are then drawn from a narrow or a wide range,
// so the window spread takes both small and large values. Every accepted
// word is run through a local copy of the window and band logic. Each result
// word is compared with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;

  import wls_pkg::*;

  typedef struct packed {
    logic [2:0]  last_band;
    logic [15:0] mean;
    logic [2:0]  mean_band;
    logic [15:0] spread;
    logic [2:0]  spread_band;
    logic [7:0]  fill;
  } stats_t;

  typedef enum logic {
    ROW_WORD,
    ROW_EDGE
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    reg_idx_e    sel;
    logic [15:0] value;
    logic        typed;
    stats_t      res;
  } dir_row_t;

  localparam stats_t NO_RES = '0;

  localparam dir_row_t DIRECTED [25] = '{
    // empty window, then both extremes
    '{ROW_WORD, REG_EDGE_ONE, 16'd0,     1'b1, '{3'd0, 16'd0,     3'd0, 16'd0,     3'd0, 8'd1}},
    '{ROW_WORD, REG_EDGE_ONE, 16'd65535, 1'b1, '{3'd4, 16'd32767, 3'd4, 16'd65535, 3'd4, 8'd2}},
    '{ROW_WORD, REG_EDGE_ONE, 16'd65535, 1'b1, '{3'd4, 16'd43690, 3'd4, 16'd65535, 3'd4, 8'd3}},
    // just below and at each default edge
    '{ROW_WORD, REG_EDGE_ONE, 16'd29,    1'b0, NO_RES},
    '{ROW_WORD, REG_EDGE_ONE, 16'd30,    1'b0, NO_RES},
    '{ROW_WORD, REG_EDGE_ONE, 16'd54,    1'b0, NO_RES},
    '{ROW_WORD, REG_EDGE_ONE, 16'd55,    1'b0, NO_RES},
    '{ROW_WORD, REG_EDGE_ONE, 16'd79,    1'b0, NO_RES},
    '{ROW_WORD, REG_EDGE_ONE, 16'd80,    1'b0, NO_RES},
    '{ROW_WORD, REG_EDGE_ONE, 16'd99,    1'b0, NO_RES},
    '{ROW_WORD, REG_EDGE_ONE, 16'd100,   1'b0, NO_RES},
    // descending edges: first edge that the value is below decides
    '{ROW_EDGE, REG_EDGE_ONE,   16'd100, 1'b0, NO_RES},
    '{ROW_EDGE, REG_EDGE_TWO,   16'd80,  1'b0, NO_RES},
    '{ROW_EDGE, REG_EDGE_THREE, 16'd55,  1'b0, NO_RES},
    '{ROW_EDGE, REG_EDGE_FOUR,  16'd30,  1'b0, NO_RES},
    '{ROW_WORD, REG_EDGE_ONE, 16'd20,    1'b0, NO_RES},
    '{ROW_WORD, REG_EDGE_ONE, 16'd60,    1'b0, NO_RES},
    '{ROW_WORD, REG_EDGE_ONE, 16'd90,    1'b0, NO_RES},
    '{ROW_WORD, REG_EDGE_ONE, 16'd120,   1'b0, NO_RES},
    // edges at both ends of the range
    '{ROW_EDGE, REG_EDGE_ONE,   16'd0,     1'b0, NO_RES},
    '{ROW_EDGE, REG_EDGE_TWO,   16'd0,     1'b0, NO_RES},
    '{ROW_EDGE, REG_EDGE_THREE, 16'd65535, 1'b0, NO_RES},
    '{ROW_EDGE, REG_EDGE_FOUR,  16'd65535, 1'b0, NO_RES},
    '{ROW_WORD, REG_EDGE_ONE, 16'd0,     1'b0, NO_RES},
    '{ROW_WORD, REG_EDGE_ONE, 16'd65535, 1'b0, NO_RES}
  };

  localparam int unsigned PHASE_SPAN [6] = '{65535, 200, 60, 65535, 150, 40};
  localparam int PHASE_WORDS = 275;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [15:0]          latency_ms_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [2:0]           last_band_o;
  logic [15:0]          window_mean_o;
  logic [2:0]           mean_band_o;
  logic [15:0]          window_spread_o;
  logic [2:0]           spread_band_o;
  logic [7:0]           fill_count_o;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [ADDR_BITS-1:0] paddr         = '0;
  logic [DATA_BITS-1:0] pwdata        = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  windowed_latency_stats_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // local copy of the window and the band edges
  logic [15:0] win_ring [WINDOW];
  int unsigned win_slot  = 0;
  int unsigned win_held  = 0;
  int unsigned win_total = 0;
  edges_t      edge_reg  = {EDGE_ONE_RST, EDGE_TWO_RST, EDGE_THREE_RST, EDGE_FOUR_RST};

  stats_t expected_q [$];
  int     mismatch_count = 0;
  int     send_idle_pct  = 0;
  int     recv_idle_pct  = 0;

  function automatic logic [2:0] band_of(input logic [15:0] v);
    if (v < edge_reg.one)   return 3'd0;
    if (v < edge_reg.two)   return 3'd1;
    if (v < edge_reg.three) return 3'd2;
    if (v < edge_reg.four)  return 3'd3;
    return 3'd4;
  endfunction

  function automatic stats_t window_stats_predict(input logic [15:0] s);
    stats_t      r;
    logic [15:0] lo;
    logic [15:0] hi;
    int unsigned mean;
    // full window: drop the overwritten sample before adding the new one
    if (win_held >= WINDOW) win_total -= win_ring[win_slot];
    win_ring[win_slot] = s;
    win_total += s;
    win_slot = (win_slot + 1 >= WINDOW) ? 0 : win_slot + 1;
    if (win_held < WINDOW) win_held++;
    lo = win_ring[0];
    hi = win_ring[0];
    for (int n = 1; n < win_held; n++) begin
      if (win_ring[n] < lo) lo = win_ring[n];
      if (win_ring[n] > hi) hi = win_ring[n];
    end
    mean          = win_total / win_held;
    r.last_band   = band_of(s);
    r.mean        = mean[15:0];
    r.mean_band   = band_of(mean[15:0]);
    r.spread      = hi - lo;
    r.spread_band = band_of(hi - lo);
    r.fill        = win_held[7:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Hold valid across back-to-back words; lower it only for a gap.
  task automatic send_word(input logic [15:0] v, input logic typed, input stats_t typed_res);
    stats_t      pred;
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    latency_ms_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = window_stats_predict(v);
    expected_q.insert(expected_q.size(), typed ? typed_res : pred);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one edge register, then read it back.
  task automatic write_edge(input reg_idx_e sel, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (sel)
      REG_EDGE_ONE:   edge_reg.one   = data[15:0];
      REG_EDGE_TWO:   edge_reg.two   = data[15:0];
      REG_EDGE_THREE: edge_reg.three = data[15:0];
      default:        edge_reg.four  = data[15:0];
    endcase
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    check_field("prdata", data[15:0], prdata[15:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    stats_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result word with no prediction pending");
        mismatch_count++;
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        check_field("last_band", want.last_band, last_band_o);
        check_field("window_mean", want.mean, window_mean_o);
        check_field("mean_band", want.mean_band, mean_band_o);
        check_field("window_spread", want.spread, window_spread_o);
        check_field("spread_band", want.spread_band, spread_band_o);
        check_field("fill_count", want.fill, fill_count_o);
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin : stimulus
    logic [15:0] ev [4];
    logic [15:0] t;
    logic [15:0] v;
    int unsigned base;
    int unsigned r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 33;
    recv_idle_pct = 48;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_EDGE) begin
        wait_drained();
        write_edge(DIRECTED[i].sel, {16'h0000, DIRECTED[i].value});
      end else begin
        send_word(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].res);
      end
    end

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      if (p < 2) begin
        send_idle_pct = 33;
        recv_idle_pct = 48;
      end else if (p < 4) begin
        send_idle_pct = 48;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < 4; k++) ev[k] = 16'($urandom());
      case (p)
        1: ev = '{default: 16'hFFFF};
        2: ev = '{default: 16'h0000};
        4: for (int k = 0; k < 4; k++) ev[k] = 16'($urandom_range(0, 300));
        5: for (int k = 0; k < 4; k++) ev[k] = 16'($urandom_range(0, 100));
        default: ;
      endcase
      // keep edges ascending except in the unordered phase
      if (p != 3) begin
        for (int a = 0; a < 3; a++) begin
          for (int b = 0; b < 3 - a; b++) begin
            if (ev[b] > ev[b+1]) begin
              t       = ev[b];
              ev[b]   = ev[b+1];
              ev[b+1] = t;
            end
          end
        end
      end
      for (int k = 0; k < 4; k++) write_edge(reg_idx_e'(k), {16'($urandom()), ev[k]});

      base = $urandom_range(0, 65535 - PHASE_SPAN[p]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ((p == 0 || p == 4) && n == PHASE_WORDS / 2) wait_drained();
        r = $urandom_range(0, 99);
        if (r < 3) begin
          v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else if (r < 9) begin
          t = ev[$urandom_range(0, 3)];
          v = $urandom_range(0, 1) ? t : t - 16'd1;
        end else begin
          v = 16'(base + $urandom_range(0, PHASE_SPAN[p]));
        end
        send_word(v, 1'b0, NO_RES);
      end
    end

    wait_drained();
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/wls_pkg.sv
rtl/wls_div.sv
rtl/wls_dp.sv
rtl/wls_ctrl.sv
rtl/windowed_latency_stats_unit.sv
rtl/wls_checker.sv
tb/tb.sv
